// File: sv/stt_pkg.sv
package stt_pkg;

  localparam int KEYWORD_CHARS = 8;
  localparam int LENGTH_BITS   = 16;
  localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // output queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // m_axis tdata: error_code, start_offset, token_length, line_number
  localparam int TD_BITS = 2 + 32 + LENGTH_BITS + 32;
  localparam int TD_W    = ((TD_BITS + 7) / 8) * 8;

  // token kinds
  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_NUMBER = 6'd1;
  localparam logic [5:0] K_STRING = 6'd2;
  localparam logic [5:0] K_END    = 6'd3;
  localparam logic [5:0] K_ERROR  = 6'd4;
  localparam logic [5:0] K_OPBASE = 6'd30;
  localparam logic [5:0] K_OP_DOT = K_OPBASE + 6'd8;

  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_UNEXP  = 2'd1;
  localparam logic [1:0] E_UNTERM = 2'd2;

  typedef struct packed {
    logic [5:0]             kind;
    logic [1:0]             err;
    logic [31:0]            start;
    logic [LENGTH_BITS-1:0] len;
    logic [31:0]            line;
    logic                   last;
  } tok_t;

  // front to queue: tokens produced by one accepted byte
  typedef struct packed {
    logic [1:0] n;
    tok_t [2:0] tok;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic can_pair(input logic [7:0] c);
    return c == "-" || c == "+" || c == "/" || c == "*" || c == "!" ||
           c == "=" || c == "<" || c == ">";
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] c);
    case (c)
      "(":     return K_OPBASE + 6'd0;
      ")":     return K_OPBASE + 6'd1;
      "{":     return K_OPBASE + 6'd2;
      "}":     return K_OPBASE + 6'd3;
      "[":     return K_OPBASE + 6'd4;
      "]":     return K_OPBASE + 6'd5;
      ";":     return K_OPBASE + 6'd6;
      ",":     return K_OPBASE + 6'd7;
      ".":     return K_OPBASE + 6'd8;
      "-":     return K_OPBASE + 6'd9;
      "+":     return K_OPBASE + 6'd12;
      "/":     return K_OPBASE + 6'd14;
      "*":     return K_OPBASE + 6'd16;
      "%":     return K_OPBASE + 6'd18;
      ":":     return K_OPBASE + 6'd19;
      "|":     return K_OPBASE + 6'd20;
      "&":     return K_OPBASE + 6'd21;
      "!":     return K_OPBASE + 6'd22;
      "=":     return K_OPBASE + 6'd24;
      "<":     return K_OPBASE + 6'd26;
      ">":     return K_OPBASE + 6'd28;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] op_pair(input logic [7:0] a, input logic [7:0] b);
    if (a == "-" && b == ">") return K_OPBASE + 6'd10;
    if (b != "=") return 6'd0;
    case (a)
      "-":     return K_OPBASE + 6'd11;
      "+":     return K_OPBASE + 6'd13;
      "/":     return K_OPBASE + 6'd15;
      "*":     return K_OPBASE + 6'd17;
      "!":     return K_OPBASE + 6'd23;
      "=":     return K_OPBASE + 6'd25;
      "<":     return K_OPBASE + 6'd27;
      ">":     return K_OPBASE + 6'd29;
      default: return 6'd0;
    endcase
  endfunction

  // keyword lookup; only the first len characters of the word are valid
  function automatic logic [5:0] kw_kind(input logic [KEYWORD_CHARS*8-1:0] w,
                                         input logic [LENGTH_BITS-1:0] len);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (LENGTH_BITS'(i) < len) acc = {acc[55:0], w[8*i +: 8]};
    end
    if (len > LENGTH_BITS'(8)) return K_IDENT;
    case (len[3:0])
      4'd2: begin
        if (acc[15:0] == "if") return 6'd14;
        if (acc[15:0] == "or") return 6'd18;
      end
      4'd3: begin
        if (acc[23:0] == "and") return 6'd5;
        if (acc[23:0] == "for") return 6'd12;
        if (acc[23:0] == "fun") return 6'd13;
        if (acc[23:0] == "int") return 6'd15;
        if (acc[23:0] == "nil") return 6'd17;
      end
      4'd4: begin
        if (acc[31:0] == "bool") return 6'd6;
        if (acc[31:0] == "else") return 6'd9;
        if (acc[31:0] == "into") return 6'd16;
        if (acc[31:0] == "null") return 6'd17;
        if (acc[31:0] == "NULL") return 6'd17;
        if (acc[31:0] == "tile") return 6'd25;
        if (acc[31:0] == "true") return 6'd26;
        if (acc[31:0] == "void") return 6'd28;
      end
      4'd5: begin
        if (acc[39:0] == "false") return 6'd10;
        if (acc[39:0] == "float") return 6'd11;
        if (acc[39:0] == "print") return 6'd20;
        if (acc[39:0] == "while") return 6'd29;
      end
      4'd6: begin
        if (acc[47:0] == "double") return 6'd8;
        if (acc[47:0] == "reduce") return 6'd21;
        if (acc[47:0] == "return") return 6'd22;
        if (acc[47:0] == "string") return 6'd23;
        if (acc[47:0] == "struct") return 6'd24;
      end
      4'd7: begin
        if (acc[55:0] == "uniform") return 6'd27;
      end
      4'd8: begin
        if (acc == "dispatch") return 6'd7;
        if (acc == "parallel") return 6'd19;
      end
      default: ;
    endcase
    return K_IDENT;
  endfunction

endpackage

// File: sv/stt_front.sv
module stt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  input  logic          eot_i,
  output stt_pkg::push_t push_o
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_ESC, M_OP, M_LCMT, M_BCMT, M_BSTAR
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [31:0]            start_q, start_d;
  logic [31:0]            pos_q, pos_d;
  logic [31:0]            line_q, line_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [KEYWORD_CHARS*8-1:0] word_q, word_d;

  logic                   fin;
  logic                   again;
  logic [1:0]             ne;
  logic [5:0]             k;
  logic [LENGTH_BITS-1:0] sat1, sat2;
  push_t                  p;

  assign sat1 = (len_q == LEN_MAX) ? LEN_MAX : len_q + LENGTH_BITS'(1);
  assign sat2 = (len_q >= LEN_MAX - LENGTH_BITS'(1)) ? LEN_MAX : len_q + LENGTH_BITS'(2);

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    start_d = start_q;
    pos_d   = pos_q;
    line_d  = line_q;
    len_d   = len_q;
    word_d  = word_q;
    fin     = eot_i || (byte_i == 8'd0);
    again   = 1'b0;
    ne      = 2'd0;
    k       = 6'd0;
    p       = '0;
    for (int i = 0; i < 3; i++) p.tok[i].line = line_q;

    case (mode_q)
      M_IDENT: begin
        if (!fin && (is_alpha(byte_i) || is_digit(byte_i))) begin
          if (len_q < LENGTH_BITS'(KEYWORD_CHARS)) word_d[8*len_q[KW_IDX_W-1:0] +: 8] = byte_i;
          len_d = sat1;
        end else begin
          p.tok[ne].kind = kw_kind(word_q, len_q);
          p.tok[ne].start = start_q; p.tok[ne].len = len_q; ne = ne + 2'd1;
          again = 1'b1;
        end
      end
      M_INT: begin
        if (!fin && is_digit(byte_i)) len_d = sat1;
        else if (!fin && byte_i == ".") mode_d = M_DOT;
        else begin
          p.tok[ne].kind = K_NUMBER;
          p.tok[ne].start = start_q; p.tok[ne].len = len_q; ne = ne + 2'd1;
          again = 1'b1;
        end
      end
      M_DOT: begin
        if (!fin && is_digit(byte_i)) begin
          len_d  = sat2;
          mode_d = M_FRAC;
        end else begin
          p.tok[ne].kind = K_NUMBER;
          p.tok[ne].start = start_q; p.tok[ne].len = len_q; ne = ne + 2'd1;
          p.tok[ne].kind = K_OP_DOT;
          p.tok[ne].start = pos_q - 32'd1; p.tok[ne].len = LENGTH_BITS'(1); ne = ne + 2'd1;
          again = 1'b1;
        end
      end
      M_FRAC: begin
        if (!fin && is_digit(byte_i)) len_d = sat1;
        else begin
          p.tok[ne].kind = K_NUMBER;
          p.tok[ne].start = start_q; p.tok[ne].len = len_q; ne = ne + 2'd1;
          again = 1'b1;
        end
      end
      M_STR, M_ESC: begin
        if (fin) begin
          p.tok[ne].kind = K_ERROR; p.tok[ne].err = E_UNTERM;
          p.tok[ne].start = start_q; p.tok[ne].len = len_q; ne = ne + 2'd1;
          again = 1'b1;
        end else begin
          len_d = sat1;
          if (byte_i == 8'h0A) line_d = line_q + 32'd1;
          if (mode_q == M_ESC) mode_d = M_STR;
          else if (byte_i == 8'h5C) mode_d = M_ESC;
          else if (byte_i == "\"") begin
            p.tok[ne].kind = K_STRING;
            p.tok[ne].start = start_q; p.tok[ne].len = sat1; ne = ne + 2'd1;
            mode_d = M_IDLE;
          end
        end
      end
      M_OP: begin
        if (!fin && pend_q == "/" && byte_i == "/") mode_d = M_LCMT;
        else if (!fin && pend_q == "/" && byte_i == "*") mode_d = M_BCMT;
        else begin
          k = fin ? 6'd0 : op_pair(pend_q, byte_i);
          if (k != 6'd0) begin
            p.tok[ne].kind = k;
            p.tok[ne].start = start_q; p.tok[ne].len = sat1; ne = ne + 2'd1;
            mode_d = M_IDLE;
          end else begin
            p.tok[ne].kind = op_single(pend_q);
            p.tok[ne].start = start_q; p.tok[ne].len = len_q; ne = ne + 2'd1;
            again = 1'b1;
          end
        end
      end
      M_LCMT: begin
        if (fin || byte_i == 8'h0A) again = 1'b1;
      end
      M_BCMT, M_BSTAR: begin
        if (fin) again = 1'b1;
        else if (byte_i == 8'h0A) begin
          line_d = line_q + 32'd1;
          mode_d = M_BCMT;
        end else if (byte_i == "*") mode_d = M_BSTAR;
        else if (byte_i == "/" && mode_q == M_BSTAR) mode_d = M_IDLE;
        else mode_d = M_BCMT;
      end
      default: again = 1'b1;
    endcase

    if (again) begin
      mode_d = M_IDLE;
      if (fin) begin
        p.tok[ne].kind = K_END;
        p.tok[ne].start = pos_q; p.tok[ne].len = '0; ne = ne + 2'd1;
        pend_d  = '0;
        start_d = '0;
        line_d  = 32'd1;
        len_d   = '0;
      end else if (byte_i == " " || byte_i == 8'h0D || byte_i == 8'h09) begin
        // blank: nothing
      end else if (byte_i == 8'h0A) begin
        line_d = line_q + 32'd1;
      end else begin
        start_d = pos_q;
        len_d   = LENGTH_BITS'(1);
        if (is_alpha(byte_i)) begin
          word_d[7:0] = byte_i;
          mode_d = M_IDENT;
        end else if (is_digit(byte_i)) mode_d = M_INT;
        else if (byte_i == "\"") mode_d = M_STR;
        else if (can_pair(byte_i)) begin
          pend_d = byte_i;
          mode_d = M_OP;
        end else begin
          k = op_single(byte_i);
          p.tok[ne].kind  = (k != 6'd0) ? k : K_ERROR;
          p.tok[ne].err   = (k != 6'd0) ? E_NONE : E_UNEXP;
          p.tok[ne].start = pos_q; p.tok[ne].len = LENGTH_BITS'(1); ne = ne + 2'd1;
        end
      end
    end
    pos_d = fin ? 32'd0 : pos_q + 32'd1;

    if (ne != 2'd0) p.tok[ne - 2'd1].last = 1'b1;
    p.n = ne;
  end

  assign push_o = accept_i ? p : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pend_q  <= '0;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= 32'd1;
      len_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) word_q <= word_d;
  end

endmodule

// File: sv/stt_queue.sv
module stt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stt_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           pop_i,
  output stt_pkg::tok_t  head_o
);
  import stt_pkg::*;

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] rd_q, wr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCNT_W'(QDEPTH - 3));
  assign head_o  = mem_q[rd_q];
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + QPTR_W'(pop);
      wr_q  <= wr_q + QPTR_W'(push_i.n);
      cnt_q <= cnt_q + QCNT_W'(push_i.n) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (QCNT_W'(i) < QCNT_W'(push_i.n)) mem_q[wr_q + QPTR_W'(i)] <= push_i.tok[i];
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o) else $error("push without room");
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> push_i.tok[push_i.n - 2'd1].last) else $error("run not closed");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.n == 2'd0) |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
    else $error("count slip");
`endif

endmodule

// File: sv/source_text_tokenizer.sv
// Channel   Dir  tdata                       tuser        tlast
// s_axis    in   text_byte[7:0]              -            end_of_text
// m_axis    out  error_code, start_offset,   token_kind   last_of_run
//                token_length, line_number (low to high)
//
// One byte is taken per cycle; each byte yields 0 to 3 tokens in the same cycle.
// Tokens wait in an 8-entry queue; s_axis_tready drops while fewer than 3 slots are free.
// Output drains one token per cycle while m_axis_tready is high, so throughput is one
// byte per cycle while the average token rate stays at or below one per cycle.
// Reset clears the scanner to idle, line 1, offset 0, and empties the queue.
module source_text_tokenizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // text_byte
  input  logic                       s_axis_tlast,   // end_of_text
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // error_code[1:0], start_offset[33:2], token_length, line_number, zero fill
  output logic [stt_pkg::TD_W-1:0]   m_axis_tdata,
  output logic [5:0]                 m_axis_tuser,   // token_kind
  output logic                       m_axis_tlast    // last_of_run
);
  import stt_pkg::*;

  push_t push;
  tok_t  head;
  logic  room;
  logic  accept;

  // a transfer is taken only when the queue can absorb a worst-case byte
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  stt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eot_i    (s_axis_tlast),
    .push_o   (push)
  );

  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = TD_W'({head.line, head.len, head.start, head.err});
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// File: sim/source_text_tokenizer_test.sv
`timescale 1ns / 1ps

module source_text_tokenizer_test;
  import stt_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE, SC_WORD, SC_INT, SC_DOT, SC_FRAC, SC_STR, SC_ESC, SC_OP,
    SC_LINE, SC_BLOCK, SC_BSTAR
  } scan_e;

  // one directed row: byte, end flag, and where obvious the kind/error of
  // the last token this byte produces (-1: predictor only)
  typedef struct {
    logic [7:0] text;
    logic       eot;
    int         kind;
    int         err;
  } row_t;

  localparam int KW_N = 27;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [TD_W-1:0] m_axis_tdata;
  logic [5:0] m_axis_tuser;
  logic m_axis_tlast;

  source_text_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // scanner shadow state
  scan_e                  sc_mode;
  logic [7:0]             sc_op;
  logic [31:0]            sc_start;
  logic [31:0]            sc_pos;
  logic [31:0]            sc_line;
  logic [LENGTH_BITS-1:0] sc_len;
  logic [7:0]             sc_word [KEYWORD_CHARS];

  tok_t token_q [$];     // tokens still owed by the DUT
  tok_t step_toks [$];   // tokens of the byte being predicted
  int   fails;
  int   n_sent;
  bit   no_idle;

  string kw_text [KW_N] = '{"and", "bool", "dispatch", "double", "else", "false",
    "float", "for", "fun", "if", "int", "into", "null", "nil", "NULL", "or",
    "parallel", "print", "reduce", "return", "string", "struct", "tile", "true",
    "uniform", "void", "while"};
  int kw_code [KW_N] = '{5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 17, 17,
    18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [LENGTH_BITS-1:0] len_add(logic [LENGTH_BITS-1:0] a, int b);
    longint s;
    s = longint'(a) + b;
    return (s > longint'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(s);
  endfunction

  // lone-character operator code, 0 when the byte is no operator
  function automatic logic [5:0] single_op(logic [7:0] c);
    string brackets;
    brackets = "(){}[];,.";
    for (int i = 0; i < 9; i++)
      if (c == brackets[i]) return 6'(30 + i);
    case (c)
      "-": return 6'd39;
      "+": return 6'd42;
      "/": return 6'd44;
      "*": return 6'd46;
      "%": return 6'd48;
      ":": return 6'd49;
      "|": return 6'd50;
      "&": return 6'd51;
      "!": return 6'd52;
      "=": return 6'd54;
      "<": return 6'd56;
      ">": return 6'd58;
      default: return 6'd0;
    endcase
  endfunction

  function automatic bit pairable(logic [7:0] c);
    return c inside {"-", "+", "/", "*", "!", "=", "<", ">"};
  endfunction

  // two-character operator code; the "=" forms sit right after the lone form, but "-=" follows "->"
  function automatic logic [5:0] pair_op(logic [7:0] a, logic [7:0] b);
    if (a == "-" && b == ">") return 6'd40;
    if (b != "=" || !pairable(a)) return 6'd0;
    return (a == "-") ? 6'd41 : single_op(a) + 6'd1;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void add_tok(logic [5:0] kind, logic [1:0] err, logic [31:0] start,
                        logic [LENGTH_BITS-1:0] len);
    tok_t t;
    if (step_toks.size() < 3) begin
      t.kind = kind; t.err = err; t.start = start; t.len = len;
      t.line = sc_line; t.last = 1'b0;
      step_toks.push_back(t);
    end
  endfunction

  function logic [5:0] word_kind();
    bit hit;
    if (sc_len > KEYWORD_CHARS) return K_IDENT;
    for (int i = 0; i < KW_N; i++) begin
      if (kw_text[i].len() == int'(sc_len)) begin
        hit = 1'b1;
        for (int j = 0; j < kw_text[i].len(); j++)
          if (sc_word[j] != kw_text[i][j]) hit = 1'b0;
        if (hit) return 6'(kw_code[i]);
      end
    end
    return K_IDENT;
  endfunction

  function void scanner_clear();
    sc_mode = SC_IDLE; sc_op = '0; sc_start = '0; sc_pos = '0;
    sc_line = 32'd1; sc_len = '0;
  endfunction

  function void begin_token(logic [7:0] c, logic [31:0] pos);
    logic [5:0] k;
    sc_mode = SC_IDLE;
    if (c inside {" ", 8'h0d, 8'h09}) return;
    if (c == 8'h0a) begin
      sc_line++;
      return;
    end
    sc_start = pos;
    sc_len = LENGTH_BITS'(1);
    if (letter(c)) begin
      sc_word[0] = c;
      sc_mode = SC_WORD;
    end else if (digit(c)) begin
      sc_mode = SC_INT;
    end else if (c == "\"") begin
      sc_mode = SC_STR;
    end else if (pairable(c)) begin
      sc_op = c;
      sc_mode = SC_OP;
    end else begin
      k = single_op(c);
      if (k != 0) add_tok(k, E_NONE, pos, LENGTH_BITS'(1));
      else add_tok(K_ERROR, E_UNEXP, pos, LENGTH_BITS'(1));
    end
  endfunction

  // predicts the tokens of one accepted byte into step_toks
  function void scan_byte(logic [7:0] c, logic eot_in);
    bit eot, restart;
    logic [31:0] pos;
    logic [5:0] k;
    eot = eot_in || c == 8'h00;
    pos = sc_pos;
    restart = 1'b0;
    step_toks.delete();
    case (sc_mode)
      SC_WORD: begin
        if (!eot && (letter(c) || digit(c))) begin
          if (sc_len < KEYWORD_CHARS) sc_word[sc_len[KW_IDX_W-1:0]] = c;
          sc_len = len_add(sc_len, 1);
        end else begin
          add_tok(word_kind(), E_NONE, sc_start, sc_len);
          restart = 1'b1;
        end
      end
      SC_INT: begin
        if (!eot && digit(c)) sc_len = len_add(sc_len, 1);
        else if (!eot && c == ".") sc_mode = SC_DOT;
        else begin
          add_tok(K_NUMBER, E_NONE, sc_start, sc_len);
          restart = 1'b1;
        end
      end
      SC_DOT: begin
        if (!eot && digit(c)) begin
          sc_len = len_add(sc_len, 2);
          sc_mode = SC_FRAC;
        end else begin
          // number, then the dot as an operator of its own
          add_tok(K_NUMBER, E_NONE, sc_start, sc_len);
          add_tok(K_OP_DOT, E_NONE, pos - 32'd1, LENGTH_BITS'(1));
          restart = 1'b1;
        end
      end
      SC_FRAC: begin
        if (!eot && digit(c)) sc_len = len_add(sc_len, 1);
        else begin
          add_tok(K_NUMBER, E_NONE, sc_start, sc_len);
          restart = 1'b1;
        end
      end
      SC_STR, SC_ESC: begin
        if (eot) begin
          add_tok(K_ERROR, E_UNTERM, sc_start, sc_len);
          restart = 1'b1;
        end else begin
          sc_len = len_add(sc_len, 1);
          if (c == 8'h0a) sc_line++;
          if (sc_mode == SC_ESC) sc_mode = SC_STR;
          else if (c == "\\") sc_mode = SC_ESC;
          else if (c == "\"") begin
            add_tok(K_STRING, E_NONE, sc_start, sc_len);
            sc_mode = SC_IDLE;
          end
        end
      end
      SC_OP: begin
        if (!eot && sc_op == "/" && c == "/") sc_mode = SC_LINE;
        else if (!eot && sc_op == "/" && c == "*") sc_mode = SC_BLOCK;
        else begin
          k = eot ? 6'd0 : pair_op(sc_op, c);
          if (k != 0) begin
            add_tok(k, E_NONE, sc_start, len_add(sc_len, 1));
            sc_mode = SC_IDLE;
          end else begin
            add_tok(single_op(sc_op), E_NONE, sc_start, sc_len);
            restart = 1'b1;
          end
        end
      end
      SC_LINE: if (eot || c == 8'h0a) restart = 1'b1;
      SC_BLOCK, SC_BSTAR: begin
        // an open block comment just ends with the text
        if (eot) restart = 1'b1;
        else if (c == 8'h0a) begin
          sc_line++;
          sc_mode = SC_BLOCK;
        end else if (c == "*") sc_mode = SC_BSTAR;
        else if (c == "/" && sc_mode == SC_BSTAR) sc_mode = SC_IDLE;
        else sc_mode = SC_BLOCK;
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      sc_mode = SC_IDLE;
      if (eot) begin
        add_tok(K_END, E_NONE, pos, LENGTH_BITS'(0));
        scanner_clear();
      end else begin
        begin_token(c, pos);
      end
    end
    if (!eot) sc_pos = pos + 32'd1;
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  // mostly zero, sometimes short, rarely long
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // one transfer on s_axis; the prediction is made at the accepting edge
  task automatic send(logic [7:0] c, logic eot, int typed_kind = -1, int typed_err = 0);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = eot;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_byte(c, eot);
    n_sent++;
    if (typed_kind >= 0 && step_toks.size() > 0) begin
      step_toks[step_toks.size() - 1].kind = 6'(typed_kind);
      step_toks[step_toks.size() - 1].err  = 2'(typed_err);
    end
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  // receiver stalls
  always @(negedge clk_i) m_axis_tready <= (gap_len() == 0);

  // compare each token transfer with the oldest expectation
  always @(posedge clk_i) begin
    tok_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind  = m_axis_tuser;
      got.err   = m_axis_tdata[1:0];
      got.start = m_axis_tdata[33:2];
      got.len   = m_axis_tdata[34 +: LENGTH_BITS];
      got.line  = m_axis_tdata[34 + LENGTH_BITS +: 32];
      got.last  = m_axis_tlast;
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token kind=%0d start=%0d", $time, got.kind, got.start);
        fails++;
      end else begin
        want = token_q.pop_front();
        if (got !== want) begin
          $display({"%0t: token mismatch expected kind=%0d err=%0d start=%0d len=%0d",
                    " line=%0d last=%0b"},
                   $time, want.kind, want.err, want.start, want.len, want.line, want.last);
          $display({"%0t:                  actual kind=%0d err=%0d start=%0d len=%0d",
                    " line=%0d last=%0b"},
                   $time, got.kind, got.err, got.start, got.len, got.line, got.last);
          fails++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // random well-formed fragment, with some noise mixed in
  task automatic send_fragment();
    string ops, s;
    int r, n;
    ops = "(){}[];,.-+/*%:|&!=<>";
    r = $urandom_range(99);
    if (r < 20) begin
      send_text(kw_text[$urandom_range(KW_N - 1)]);
    end else if (r < 35) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(14, 9) : $urandom_range(6, 1);
      send(letter(8'($urandom_range(122, 65))) ? 8'($urandom_range(122, 97)) : "_", 1'b0);
      for (int i = 1; i < n; i++)
        send(($urandom_range(3) == 0) ? 8'($urandom_range(57, 48)) : 8'($urandom_range(122, 97)),
             1'b0);
    end else if (r < 47) begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) send(8'($urandom_range(57, 48)), 1'b0);
      if ($urandom_range(1)) begin
        send(".", 1'b0);
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) send(8'($urandom_range(57, 48)), 1'b0);
      end
    end else if (r < 57) begin
      send("\"", 1'b0);
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(5))
          0: send_text("\\\"");
          1: send(8'h0a, 1'b0);
          default: send(8'($urandom_range(126, 32)) == "\"" ? "x" : 8'($urandom_range(126, 35)),
                        1'b0);
        endcase
      end
      if ($urandom_range(7) != 0) send("\"", 1'b0);
    end else if (r < 75) begin
      send(ops[$urandom_range(ops.len() - 1)], 1'b0);
      if ($urandom_range(1)) send(($urandom_range(3) == 0) ? ">" : "=", 1'b0);
    end else if (r < 80) begin
      if ($urandom_range(1)) s = "// note\n";
      else s = "/* a *\n* b **/";
      send_text(s);
    end else if (r < 90) begin
      s = " \t\r\n";
      send(s[$urandom_range(3)], 1'b0);
    end else if (r < 97) begin
      send(8'($urandom_range(255)), 1'b0);
    end else begin
      send(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    row_t rows [$];
    string dir;
    int waited;

    fails = 0;
    n_sent = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    scanner_clear();
    foreach (sc_word[i]) sc_word[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: errors, keyword, number with bare dot, escaped string with
    // newline, block comment, two-char operators, end, unterminated string
    rows.push_back('{"@",   1'b0, 4, 1});
    rows.push_back('{8'hff, 1'b0, 4, 1});
    dir = "int 1.x\"\\\"\n\"/**/->!=";
    foreach (dir[i]) rows.push_back('{dir[i], 1'b0, -1, 0});
    rows.push_back('{8'h00, 1'b1, 3, 0});
    rows.push_back('{"\"",  1'b0, -1, 0});
    rows.push_back('{"a",   1'b0, -1, 0});
    rows.push_back('{8'h55, 1'b1, 3, 0});
    foreach (rows[i]) send(rows[i].text, rows[i].eot, rows[i].kind, rows[i].err);

    while (n_sent < 500) begin
      no_idle = ($urandom_range(9) == 0);
      send_fragment();
      send(" ", 1'b0);
    end
    no_idle = 1'b0;
    send(8'h00, 1'b1);

    waited = 0;
    while (token_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (fails == 0 && token_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/source_text_tokenizer.sv
sim/source_text_tokenizer_test.sv
